// ===== hdl/lrwc_pkg.sv =====
// Shared types and constants for the LRU region window cache.
// No dependencies; the cache top level refers to it by scoped names.
package lrwc_pkg;

    localparam int IDX_W       = 40;   // item index and region start
    localparam int CFG_W       = 41;   // region size, item count, region end
    localparam int STAMP_W     = 64;   // use counter and slot stamps
    localparam int SLOT_OUT_W  = 6;    // slot number on the result word
    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 88;
    localparam int TUSER_OUT_W = 3;
    localparam int CFG_ADDR_W  = 1;
    localparam int DIV_CNT_W   = $clog2(IDX_W);
    localparam int SLOTS_DEFAULT = 8;

    localparam logic [CFG_W-1:0] RESET_REGION_SIZE = CFG_W'(512);
    localparam logic [CFG_W-1:0] RESET_ITEM_COUNT  = '0;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_SIZE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_ITEM_COUNT  = CFG_ADDR_W'(1);

    // result tuser bit positions
    localparam int USER_RANGE_ERROR = 0;
    localparam int USER_HIT         = 1;
    localparam int USER_REPLACED    = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_START,
        S_END,
        S_SEARCH,
        S_VICTIM,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

// ===== hdl/lru_region_window_cache_top.sv =====
// LRU region window cache: index-to-region mapping plus fully associative slot set.
// Depends on lrwc_pkg (types, widths, register indexes).
//
//  channel  | ports                      | word contents (lowest bit up)
//  ---------+----------------------------+---------------------------------------------
//  input    | s_tvalid s_tready s_tdata  | item_index[39:0]
//  result   | m_tvalid m_tready m_tdata  | slot[5:0] region_start[45:6] region_end[86:46]
//           | m_tuser                    | range_error, hit, replaced
//  config   | cfg_we cfg_addr cfg_wdata  | 0: region_size, 1: item_count
//
// A word holds the block from the range check, which ends it on a range error; else
// the 40-step remainder unit runs, then a one-slot-a-cycle tag scan and, when full,
// a one-slot-a-cycle stamp scan.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next word is accepted while it is unread.
// Reset (aresetn, synchronous) empties the slot set and clears the use counter.
module lru_region_window_cache_top #(
    parameter int SLOTS = lrwc_pkg::SLOTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lrwc_pkg::TDATA_IN_W-1:0]     s_tdata,   // item_index
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrwc_pkg::TDATA_OUT_W-1:0]    m_tdata,   // slot, region_start, region_end
    output logic [lrwc_pkg::TUSER_OUT_W-1:0]    m_tuser,   // range_error, hit, replaced
    input  logic                                cfg_we,
    input  logic [lrwc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lrwc_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int IDX_W   = lrwc_pkg::IDX_W;
    localparam int CFG_W   = lrwc_pkg::CFG_W;
    localparam int STAMP_W = lrwc_pkg::STAMP_W;
    localparam int DCNT_W  = lrwc_pkg::DIV_CNT_W;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // control state
    lrwc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [STAMP_W-1:0] use_cnt_reg, use_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]   region_size_reg, item_count_reg;

    // datapath
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   sh_reg, sh_next;
    logic [IDX_W-1:0]   rem_reg, rem_next;
    logic [DCNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [STAMP_W-1:0] best_reg, best_next;
    logic               err_reg, err_next;
    logic               hit_reg, hit_next;
    logic               repl_reg, repl_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [CFG_W-1:0]   end_reg, end_next;
    logic [lrwc_pkg::TDATA_OUT_W-1:0] out_data_reg, out_data_next;
    logic [lrwc_pkg::TUSER_OUT_W-1:0] out_user_reg, out_user_next;

    // slot set
    logic [IDX_W-1:0]   slot_start_reg [SLOTS];
    logic [STAMP_W-1:0] slot_stamp_reg [SLOTS];

    // shared decode
    logic [CFG_W-1:0]   size_eff;
    logic [SLOT_W-1:0]  scan_idx;
    logic               range_err;
    logic               search_hit;
    logic               scan_last;
    logic               full;
    logic               scan_done;
    logic               out_free;
    logic [IDX_W:0]     rem_shift;
    logic [IDX_W+1:0]   div_diff;
    logic [CFG_W:0]     end_sum;

    assign size_eff   = (region_size_reg == '0) ? CFG_W'(1) : region_size_reg;
    assign scan_idx   = scan_reg[SLOT_W-1:0];
    assign range_err  = {1'b0, idx_reg} >= item_count_reg;
    assign search_hit = (slot_start_reg[scan_idx] == start_reg);
    assign scan_last  = (scan_reg + CNT_W'(1)) == filled_reg;
    assign full       = (filled_reg == CNT_W'(SLOTS));
    assign scan_done  = (scan_reg == CNT_W'(SLOTS));
    assign rem_shift  = {rem_reg, sh_reg[IDX_W-1]};
    assign div_diff   = {1'b0, rem_shift} - {1'b0, size_eff};
    assign end_sum    = {2'b00, start_reg} + {1'b0, size_eff};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lrwc_pkg::S_IDLE:   if (s_tvalid) state_next = lrwc_pkg::S_CHECK;
            lrwc_pkg::S_CHECK:  state_next = range_err ? lrwc_pkg::S_DONE : lrwc_pkg::S_DIV;
            lrwc_pkg::S_DIV:    if (div_cnt_reg == '0) state_next = lrwc_pkg::S_START;
            lrwc_pkg::S_START:  state_next = lrwc_pkg::S_END;
            lrwc_pkg::S_END: begin
                state_next = (filled_reg == '0) ? lrwc_pkg::S_WRITE : lrwc_pkg::S_SEARCH;
            end
            lrwc_pkg::S_SEARCH: begin
                if (search_hit) begin
                    state_next = lrwc_pkg::S_DONE;
                end else if (scan_last) begin
                    state_next = full ? lrwc_pkg::S_VICTIM : lrwc_pkg::S_WRITE;
                end
            end
            lrwc_pkg::S_VICTIM: if (scan_done) state_next = lrwc_pkg::S_WRITE;
            lrwc_pkg::S_WRITE:  state_next = lrwc_pkg::S_DONE;
            lrwc_pkg::S_DONE:   if (out_free) state_next = lrwc_pkg::S_IDLE;
            default:            state_next = lrwc_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == lrwc_pkg::S_IDLE);
        out_free = !out_valid_reg || m_tready;
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tuser  = out_user_reg;
    end

    // datapath next values
    always_comb begin
        filled_next    = filled_reg;
        use_cnt_next   = use_cnt_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        scan_next      = scan_reg;
        best_next      = best_reg;
        err_next       = err_reg;
        hit_next       = hit_reg;
        repl_next      = repl_reg;
        slot_next      = slot_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lrwc_pkg::S_IDLE: begin
                if (s_tvalid) idx_next = s_tdata[IDX_W-1:0];
            end
            lrwc_pkg::S_CHECK: begin
                err_next  = range_err;
                hit_next  = 1'b0;
                repl_next = 1'b0;
                slot_next = '0;
                start_next = '0;
                end_next   = '0;
                rem_next     = '0;
                sh_next      = idx_reg;
                div_cnt_next = DCNT_W'(IDX_W - 1);
            end
            lrwc_pkg::S_DIV: begin
                // restoring remainder step, one index bit per cycle
                rem_next     = div_diff[IDX_W+1] ? rem_shift[IDX_W-1:0] : div_diff[IDX_W-1:0];
                sh_next      = sh_reg << 1;
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
            end
            lrwc_pkg::S_START: begin
                start_next = idx_reg - rem_reg;
            end
            lrwc_pkg::S_END: begin
                end_next     = (end_sum > {1'b0, item_count_reg}) ? item_count_reg
                                                                  : end_sum[CFG_W-1:0];
                use_cnt_next = use_cnt_reg + STAMP_W'(1);
                scan_next    = '0;
                slot_next    = '0;
            end
            lrwc_pkg::S_SEARCH: begin
                if (search_hit) begin
                    hit_next  = 1'b1;
                    slot_next = scan_idx;
                end else if (scan_last) begin
                    if (full) begin
                        // seed the oldest-stamp scan with slot 0
                        best_next = slot_stamp_reg[0];
                        slot_next = '0;
                        scan_next = CNT_W'(1);
                    end else begin
                        slot_next = filled_reg[SLOT_W-1:0];
                    end
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            lrwc_pkg::S_VICTIM: begin
                if (scan_done) begin
                    repl_next = 1'b1;
                end else begin
                    // strict less-than keeps the lowest slot on ties
                    if (slot_stamp_reg[scan_idx] < best_reg) begin
                        best_next = slot_stamp_reg[scan_idx];
                        slot_next = scan_idx;
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            lrwc_pkg::S_WRITE: begin
                if (!full) filled_next = filled_reg + CNT_W'(1);
            end
            lrwc_pkg::S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, end_reg, start_reg,
                                      lrwc_pkg::SLOT_OUT_W'(slot_reg)};
                    out_user_next  = {repl_reg, hit_reg, err_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lrwc_pkg::S_IDLE;
            filled_reg      <= '0;
            use_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            region_size_reg <= lrwc_pkg::RESET_REGION_SIZE;
            item_count_reg  <= lrwc_pkg::RESET_ITEM_COUNT;
        end else begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            use_cnt_reg   <= use_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_addr == lrwc_pkg::REG_REGION_SIZE) region_size_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == lrwc_pkg::REG_ITEM_COUNT)  item_count_reg  <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        scan_reg     <= scan_next;
        best_reg     <= best_next;
        err_reg      <= err_next;
        hit_reg      <= hit_next;
        repl_reg     <= repl_next;
        slot_reg     <= slot_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // slot set writes: stamp refresh on a hit, full entry on a fill or eviction
    always_ff @(posedge aclk) begin
        if (state_reg == lrwc_pkg::S_SEARCH && search_hit) begin
            slot_stamp_reg[scan_idx] <= use_cnt_reg;
        end
        if (state_reg == lrwc_pkg::S_WRITE) begin
            slot_start_reg[slot_reg] <= start_reg;
            slot_stamp_reg[slot_reg] <= use_cnt_reg;
        end
    end

`ifndef SYNTH
    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(SLOTS))
        else $error("slot fill count above slot total");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[lrwc_pkg::USER_RANGE_ERROR] |->
            !m_tuser[lrwc_pkg::USER_HIT] && !m_tuser[lrwc_pkg::USER_REPLACED] && m_tdata == '0)
        else $error("range error result carries nonzero fields");

    a_repl_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[lrwc_pkg::USER_REPLACED] |-> full && !m_tuser[lrwc_pkg::USER_HIT])
        else $error("eviction reported while slots were free or on a hit");

    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && state_reg != lrwc_pkg::S_END |=> $stable(use_cnt_reg))
        else $error("use counter moved outside the region end step");
`endif

endmodule
